@@ sv/tli_pkg.sv @@
// Shared widths, codes and types of the table linear interpolator.
package tli_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	localparam int POS_W    = 32;
	localparam int DENS_W   = 40;
	localparam int IDX_W    = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 3;

	localparam int RAM_W = POS_W + DENS_W;

	// datapath widths: magnitudes of position differences, split multiplier, divider
	localparam int MAG_W     = POS_W + 1;
	localparam int HALF_W    = DENS_W / 2;
	localparam int MUL_W     = HALF_W + MAG_W;
	localparam int PROD_W    = DENS_W + MAG_W;
	localparam int DIV_W     = PROD_W + (PROD_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TABLE_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_BELOW = 3'd1,
		ST_ABOVE = 3'd2,
		ST_FLAT  = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

endpackage

@@ sv/tli_in_if.sv @@
// Input word channel: table write or interpolation query.
interface tli_in_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [tli_pkg::IDX_W-1:0]       entry_index;
	logic signed [tli_pkg::POS_W-1:0] entry_position;
	logic [tli_pkg::DENS_W-1:0]      entry_density;
	logic signed [tli_pkg::POS_W-1:0] query_position;

	modport source (
		output valid, command, entry_index, entry_position, entry_density, query_position,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, entry_position, entry_density, query_position,
		output ready
	);
endinterface

@@ sv/tli_out_if.sv @@
// Output word channel: interpolated density and status.
interface tli_out_if;
	logic                          valid;
	logic                          ready;
	logic [tli_pkg::DENS_W-1:0]    density;
	logic [tli_pkg::STATUS_W-1:0]  status;

	modport source (
		output valid, density, status,
		input  ready
	);
	modport sink (
		input  valid, density, status,
		output ready
	);
endinterface

@@ sv/tli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/table_linear_interpolator_top.sv @@
// Table linear interpolator: bisection over a table RAM, split multiply, radix-4 divide.
// A write word goes to the table RAM when accepted. A query runs k bisection steps,
// k = ceil(log2(table_length-1)), each a read and a compare on the single RAM read
// port, then the split multiply and the 2-bit divider, before the result register.
// A zero-width segment skips multiply and divide.
// Reset sets table_length to 2 and empties the output register; table contents stay
// undefined until written and get no clearing pass.
module table_linear_interpolator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	tli_in_if.sink                         in_ch,
	tli_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tli_pkg::PADDR_W-1:0]    paddr,
	input  logic [tli_pkg::PDATA_W-1:0]    pwdata,
	output logic [tli_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RDN, S_CAPN, S_BIS_RD, S_BIS_CMP, S_SEG1, S_SEG2,
		S_ABS, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [tli_pkg::LEN_W-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= tli_pkg::LEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == tli_pkg::REG_TABLE_LENGTH) begin
			len_q <= pwdata[tli_pkg::LEN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tli_pkg::REG_TABLE_LENGTH) ?
		tli_pkg::PDATA_W'(len_q) : '0;

	// last index in use, length clamped to 2..TABLE_DEPTH
	logic [tli_pkg::ADDR_W-1:0] last_idx;

	always_comb begin
		if (len_q < tli_pkg::LEN_W'(2)) begin
			last_idx = tli_pkg::ADDR_W'(1);
		end else if (32'(len_q) > tli_pkg::TABLE_DEPTH) begin
			last_idx = tli_pkg::ADDR_W'(tli_pkg::TABLE_DEPTH - 1);
		end else begin
			last_idx = tli_pkg::ADDR_W'(len_q - tli_pkg::LEN_W'(1));
		end
	end

	// handshakes
	logic in_acc;
	logic wr_en;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign wr_en       = in_acc && (in_ch.command == tli_pkg::CMD_WRITE) &&
		(32'(in_ch.entry_index) < tli_pkg::TABLE_DEPTH);

	// table RAM: position in the upper bits, density in the lower
	logic [tli_pkg::ADDR_W-1:0] raddr;
	logic [tli_pkg::RAM_W-1:0]  rdata;
	logic signed [tli_pkg::POS_W-1:0] rd_pos;
	logic [tli_pkg::DENS_W-1:0] rd_dens;

	tli_ram #(
		.WIDTH(tli_pkg::RAM_W),
		.DEPTH(tli_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tli_pkg::ADDR_W'(in_ch.entry_index)),
		.wdata({in_ch.entry_position, in_ch.entry_density}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_pos  = rdata[tli_pkg::RAM_W-1:tli_pkg::DENS_W];
	assign rd_dens = rdata[tli_pkg::DENS_W-1:0];

	// bisection bounds
	logic [tli_pkg::ADDR_W-1:0] lo_q, hi_q, mid;
	logic [tli_pkg::ADDR_W:0]   bound_sum;
	logic                       span_open;

	assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = bound_sum[tli_pkg::ADDR_W:1];
	assign span_open = (hi_q - lo_q) > tli_pkg::ADDR_W'(1);

	always_comb begin
		case (state_q)
			S_RDN:              raddr = last_idx;
			S_CAPN, S_BIS_RD:   raddr = span_open ? mid : lo_q;
			S_BIS_CMP:          raddr = mid;
			S_SEG1:             raddr = lo_q + tli_pkg::ADDR_W'(1);
			default:            raddr = '0;
		endcase
	end

	// datapath registers
	logic signed [tli_pkg::POS_W-1:0] x_q, p0_q;
	logic [tli_pkg::DENS_W-1:0]       d0_q;
	logic                             below_q, above_q;
	logic signed [tli_pkg::MAG_W-1:0] dp_q, b_q;
	logic signed [tli_pkg::DENS_W:0]  dd_q;
	logic [tli_pkg::DENS_W-1:0]       amag_q;
	logic [tli_pkg::MAG_W-1:0]        bmag_q, dmag_q;
	logic                             neg_q, flat_q;
	logic [tli_pkg::MUL_W-1:0]        prod_q;
	logic [tli_pkg::DIV_W-1:0]        dv_q;
	logic [tli_pkg::MAG_W-1:0]        r_q;
	logic [tli_pkg::CNT_W-1:0]        cnt_q;

	// shared 20 x 33 multiplier, low half of the density difference first
	logic [tli_pkg::HALF_W-1:0] mul_a;
	logic [tli_pkg::MUL_W-1:0]  mul_out;

	assign mul_a   = (state_q == S_MUL0) ? amag_q[tli_pkg::HALF_W-1:0] :
		amag_q[tli_pkg::DENS_W-1:tli_pkg::HALF_W];
	assign mul_out = tli_pkg::MUL_W'(mul_a) * tli_pkg::MUL_W'(bmag_q);

	// two restoring divide steps per cycle; quotient bits shift in as dividend bits leave
	logic [tli_pkg::MAG_W:0]   dext, t1, t2, r1, r2;
	logic                      ge1, ge2;

	assign dext = {1'b0, dmag_q};
	assign t1   = {r_q, dv_q[tli_pkg::DIV_W-1]};
	assign ge1  = t1 >= dext;
	assign r1   = ge1 ? t1 - dext : t1;
	assign t2   = {r1[tli_pkg::MAG_W-1:0], dv_q[tli_pkg::DIV_W-2]};
	assign ge2  = t2 >= dext;
	assign r2   = ge2 ? t2 - dext : t2;

	// final add or subtract with saturation; a flat segment passes d0 through
	logic                       q_big, r_nz, q_zero;
	logic [tli_pkg::DENS_W-1:0] ql;
	logic [tli_pkg::DENS_W:0]   sum;
	tli_pkg::status_t           base_st, res_st;
	logic [tli_pkg::DENS_W-1:0] res_dens;

	assign q_big  = |dv_q[tli_pkg::DIV_W-1:tli_pkg::DENS_W];
	assign ql     = dv_q[tli_pkg::DENS_W-1:0];
	assign r_nz   = |r_q;
	assign q_zero = !q_big && (ql == '0) && !r_nz;
	assign sum    = {1'b0, d0_q} + {1'b0, ql};

	always_comb begin
		if (below_q) begin
			base_st = tli_pkg::ST_BELOW;
		end else if (above_q) begin
			base_st = tli_pkg::ST_ABOVE;
		end else begin
			base_st = tli_pkg::ST_OK;
		end

		if (flat_q) begin
			res_dens = d0_q;
			res_st   = tli_pkg::ST_FLAT;
		end else if (!neg_q || q_zero) begin
			if (q_big || sum[tli_pkg::DENS_W]) begin
				res_dens = '1;
				res_st   = tli_pkg::ST_SAT;
			end else begin
				res_dens = sum[tli_pkg::DENS_W-1:0];
				res_st   = base_st;
			end
		end else if (!q_big && ql <= d0_q) begin
			// truncate toward zero: drop one more when a fraction remains above zero
			res_dens = d0_q - ql - tli_pkg::DENS_W'(r_nz && (ql < d0_q));
			res_st   = base_st;
		end else begin
			res_dens = '0;
			res_st   = tli_pkg::ST_SAT;
		end
	end

	// sequencer and output register
	logic                        out_valid_q;
	logic [tli_pkg::DENS_W-1:0]  out_density_q;
	tli_pkg::status_t            out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			lo_q          <= '0;
			hi_q          <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
			out_density_q <= '0;
			out_status_q  <= tli_pkg::ST_OK;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.command == tli_pkg::CMD_QUERY) begin
						lo_q    <= '0;
						hi_q    <= last_idx;
						state_q <= S_RD0;
					end
				end
				S_RD0:  state_q <= S_RDN;
				S_RDN:  state_q <= S_CAPN;
				S_CAPN, S_BIS_RD: begin
					state_q <= span_open ? S_BIS_CMP : S_SEG1;
				end
				S_BIS_CMP: begin
					if (rd_pos <= x_q) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_BIS_RD;
				end
				S_SEG1: state_q <= S_SEG2;
				S_SEG2: state_q <= S_ABS;
				S_ABS:  state_q <= (dp_q == '0) ? S_FIN : S_MUL0;
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + tli_pkg::CNT_W'(1);
					if (cnt_q == tli_pkg::CNT_W'(tli_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q   <= 1'b1;
						out_density_q <= res_dens;
						out_status_q  <= res_st;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					x_q <= in_ch.query_position;
				end
			end
			S_RDN:  below_q <= x_q < rd_pos;
			S_CAPN: above_q <= x_q > rd_pos;
			S_SEG1: begin
				p0_q <= rd_pos;
				d0_q <= rd_dens;
			end
			S_SEG2: begin
				dp_q <= {rd_pos[tli_pkg::POS_W-1], rd_pos} - {p0_q[tli_pkg::POS_W-1], p0_q};
				b_q  <= {x_q[tli_pkg::POS_W-1], x_q} - {p0_q[tli_pkg::POS_W-1], p0_q};
				dd_q <= {1'b0, rd_dens} - {1'b0, d0_q};
			end
			S_ABS: begin
				amag_q <= dd_q[tli_pkg::DENS_W] ? tli_pkg::DENS_W'(-dd_q) :
					dd_q[tli_pkg::DENS_W-1:0];
				bmag_q <= b_q[tli_pkg::MAG_W-1] ? -b_q : b_q;
				dmag_q <= dp_q[tli_pkg::MAG_W-1] ? -dp_q : dp_q;
				neg_q  <= dd_q[tli_pkg::DENS_W] ^ b_q[tli_pkg::MAG_W-1] ^ dp_q[tli_pkg::MAG_W-1];
				flat_q <= (dp_q == '0);
			end
			S_MUL0: prod_q <= mul_out;
			S_MUL1: begin
				dv_q   <= tli_pkg::DIV_W'(prod_q);
				prod_q <= mul_out;
			end
			S_MUL2: begin
				dv_q <= dv_q + (tli_pkg::DIV_W'(prod_q) << tli_pkg::HALF_W);
				r_q  <= '0;
			end
			S_DIV: begin
				dv_q <= {dv_q[tli_pkg::DIV_W-3:0], ge1, ge2};
				r_q  <= r2[tli_pkg::MAG_W-1:0];
			end
			default: ;
		endcase
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.density = out_density_q;
	assign out_ch.status  = out_status_q;

endmodule

@@ tb/table_linear_interpolator_top_tb.sv @@
// Self-checking testbench of the table linear interpolator: table writes, queries, length register.
module table_linear_interpolator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tli_pkg::*;

	typedef struct packed {
		logic                     command;
		logic [IDX_W-1:0]         entry_index;
		logic signed [POS_W-1:0]  entry_position;
		logic [DENS_W-1:0]        entry_density;
		logic signed [POS_W-1:0]  query_position;
	} in_word_t;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		status_t           status;
	} result_t;

	typedef struct packed {
		in_word_t w;
		logic     typed;
		result_t  res;
	} plan_row_t;

	localparam logic [DENS_W-1:0]       DENS_TOP = '1;
	localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_ONE  = 32'sh0100_0000;
	localparam logic [PADDR_W-1:0]      LEN_ADDR = PADDR_W'({REG_TABLE_LENGTH, 2'b00});

	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 63;
	localparam int DRAIN_CYCLES    = 100;
	localparam int SETTLE_LIMIT    = 20000;
	localparam int MAX_SHOWN       = 50;
	localparam int PLAN_LEN        = 25;

	// expected values typed in only where the arithmetic is obvious
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{'{CMD_WRITE, 10'd0, 32'sh0, 40'h0, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_WRITE, 10'd1, POS_ONE, 40'h1000, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh0}, 1'b1, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_ONE}, 1'b1, '{40'h1000, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh0200_0000}, 1'b1, '{40'h2000, ST_ABOVE}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_MAX}, 1'b1, '{40'h7FFFF, ST_ABOVE}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'shFF00_0000}, 1'b1, '{40'h0, ST_SAT}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_MIN}, 1'b1, '{40'h0, ST_SAT}},
		'{'{CMD_WRITE, 10'd0, 32'sh0, DENS_TOP, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_WRITE, 10'd1, POS_ONE, 40'hFF_FFFF_FF00, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'shFF00_0000}, 1'b1, '{DENS_TOP, ST_SAT}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_ONE}, 1'b1, '{40'hFF_FFFF_FF00, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh0080_0000}, 1'b1,
			'{40'hFF_FFFF_FF7F, ST_OK}},
		'{'{CMD_WRITE, 10'd1, 32'sh0, 40'h0, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh5}, 1'b1, '{DENS_TOP, ST_FLAT}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_MIN}, 1'b1, '{DENS_TOP, ST_FLAT}},
		'{'{CMD_WRITE, 10'd0, POS_MIN, 40'h0, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_WRITE, 10'd1, POS_MAX, DENS_TOP, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_MAX}, 1'b1, '{DENS_TOP, ST_OK}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, POS_MIN}, 1'b1, '{40'h0, ST_OK}},
		'{'{CMD_WRITE, 10'd0, 32'sh0, 40'h1, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		'{'{CMD_WRITE, 10'd1, 32'sh3, 40'h0, 32'sh0}, 1'b0, '{40'h0, ST_OK}},
		// a fraction just below zero truncates to zero without saturating
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh4}, 1'b1, '{40'h0, ST_ABOVE}},
		'{'{CMD_QUERY, 10'd0, 32'sh0, 40'h0, 32'sh6}, 1'b1, '{40'h0, ST_SAT}}
	};

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	tli_in_if  in_bus ();
	tli_out_if out_bus ();

	table_linear_interpolator_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_bus),
		.out_ch  (out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the block's table and length register
	logic signed [POS_W-1:0] pos_tab [TABLE_DEPTH];
	logic [DENS_W-1:0]       dens_tab [TABLE_DEPTH];
	bit                      table_written [TABLE_DEPTH];
	logic [LEN_W-1:0]        len_reg = LEN_RESET;

	result_t pending_results [$];

	int errors          = 0;
	int words_sent      = 0;
	int queries_sent    = 0;
	int results_checked = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("table_linear_interpolator_top test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < MAX_SHOWN)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned effective_length(input logic [LEN_W-1:0] len);
		if (len < 2)
			return 2;
		if (len > TABLE_DEPTH)
			return TABLE_DEPTH;
		return len;
	endfunction

	// bisect, extrapolate at the ends, truncate toward zero, clamp to the density range
	function automatic result_t interpolate_density(input logic signed [POS_W-1:0] x);
		int unsigned       n, lo, hi, mid;
		longint            p0, p1, dp, b;
		logic [DENS_W-1:0] d0, d1;
		logic [63:0]       amag, bmag, dmag;
		logic [127:0]      prod, quo, rem, sum;
		bit                neg;
		result_t           res;
		n  = effective_length(len_reg);
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (pos_tab[mid] <= x)
				lo = mid;
			else
				hi = mid;
		end
		res.status = ST_OK;
		if (x < pos_tab[0])
			res.status = ST_BELOW;
		else if (x > pos_tab[n-1])
			res.status = ST_ABOVE;
		p0 = longint'(pos_tab[lo]);
		p1 = longint'(pos_tab[lo+1]);
		d0 = dens_tab[lo];
		d1 = dens_tab[lo+1];
		dp = p1 - p0;
		if (dp == 0) begin
			res.density = d0;
			res.status  = ST_FLAT;
			return res;
		end
		b    = longint'(x) - p0;
		amag = (d1 >= d0) ? 64'(d1 - d0) : 64'(d0 - d1);
		bmag = (b >= 0) ? 64'(b) : 64'(-b);
		dmag = (dp >= 0) ? 64'(dp) : 64'(-dp);
		neg  = ((d1 < d0) != (b < 0)) != (dp < 0);
		prod = 128'(amag) * 128'(bmag);
		quo  = prod / 128'(dmag);
		rem  = prod % 128'(dmag);
		if (!neg || prod == 0) begin
			sum = 128'(d0) + quo;
			if (sum > 128'(DENS_TOP)) begin
				res.density = DENS_TOP;
				res.status  = ST_SAT;
			end else begin
				res.density = sum[DENS_W-1:0];
			end
		end else if (quo <= 128'(d0)) begin
			res.density = d0 - quo[DENS_W-1:0];
			if (rem != 0 && quo < 128'(d0))
				res.density = res.density - 1'b1;
		end else begin
			res.density = '0;
			res.status  = ST_SAT;
		end
		return res;
	endfunction

	function automatic longint rand_span(input longint a, input longint b);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return a + longint'(r % 64'(b - a + 1));
	endfunction

	function automatic logic [DENS_W-1:0] pick_density();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return DENS_W'({$urandom, $urandom});
		if (r < 75)
			return DENS_W'($urandom_range(0, 4095));
		if (r < 85)
			return '0;
		if (r < 95)
			return DENS_TOP;
		return DENS_TOP - DENS_W'($urandom_range(0, 4095));
	endfunction

	function automatic logic signed [POS_W-1:0] pick_query(input int unsigned eff);
		int unsigned r;
		longint      mn, mx, v;
		mn = longint'(pos_tab[0]);
		mx = longint'(pos_tab[eff-1]);
		if (mn > mx) begin
			v  = mn;
			mn = mx;
			mx = v;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			v = rand_span(mn, mx);
		else if (r < 65)
			v = longint'(pos_tab[$urandom_range(0, eff-1)]);
		else if (r < 80)
			v = longint'($signed($urandom));
		else if (r < 90)
			v = $urandom_range(0, 1) ? mn - $urandom_range(1, 1000) : mx + $urandom_range(1, 1000);
		else
			v = $urandom_range(0, 1) ? longint'(POS_MIN) : longint'(POS_MAX);
		if (v < longint'(POS_MIN))
			v = longint'(POS_MIN);
		if (v > longint'(POS_MAX))
			v = longint'(POS_MAX);
		return POS_W'(v);
	endfunction

	function automatic int pick_gap(input bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic in_word_t noise_word();
		in_word_t w;
		w.command        = CMD_QUERY;
		w.entry_index    = IDX_W'($urandom);
		w.entry_position = POS_W'($urandom);
		w.entry_density  = DENS_W'({$urandom, $urandom});
		w.query_position = POS_W'($urandom);
		return w;
	endfunction

	// offer one word, hold it until accepted, then predict and sometimes idle
	task automatic drive_word(input in_word_t w, input bit typed, input result_t typed_res,
			input bit quiet);
		int gap;
		bit pause;
		in_bus.valid          <= 1'b1;
		in_bus.command        <= w.command;
		in_bus.entry_index    <= w.entry_index;
		in_bus.entry_position <= w.entry_position;
		in_bus.entry_density  <= w.entry_density;
		in_bus.query_position <= w.query_position;
		do
			@(posedge clk);
		while (in_bus.ready !== 1'b1);
		words_sent++;
		if (w.command == CMD_WRITE) begin
			pos_tab[w.entry_index]       = w.entry_position;
			dens_tab[w.entry_index]      = w.entry_density;
			table_written[w.entry_index] = 1'b1;
		end else begin
			queries_sent++;
			pending_results.push_back(typed ? typed_res : interpolate_density(w.query_position));
		end
		gap   = pick_gap(quiet);
		pause = ($urandom_range(0, 59) == 0);
		// a pause always comes with a nonzero idle gap after valid drops
		if (pause && gap == 0)
			gap = 1;
		if (gap > 0 || pause) begin
			in_bus.valid <= 1'b0;
			// drain the block completely before the next word
			if (pause)
				while (pending_results.size() != 0)
					@(posedge clk);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_bus.valid <= 1'b0;
		for (int c = 0; c < SETTLE_LIMIT && pending_results.size() != 0; c++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// load slots 0..eff-1 with a sorted table, sometimes descending, with a few flat segments
	task automatic fill_table(input int unsigned eff, input bit quiet);
		longint   span, base, prev, cur;
		bit       desc;
		in_word_t w;
		span = (64'h1_0000_0000 / eff) >> $urandom_range(0, 16);
		base = longint'(POS_MIN) + rand_span(0, 64'h1_0000_0000 - longint'(eff) * span);
		desc = ($urandom_range(0, 9) == 0);
		prev = base;
		for (int unsigned k = 0; k < eff; k++) begin
			if (k > 0 && $urandom_range(0, 19) == 0)
				cur = prev;
			else
				cur = base + longint'(k) * span + rand_span(0, span - 1);
			prev             = cur;
			w                = noise_word();
			w.command        = CMD_WRITE;
			w.entry_index    = IDX_W'(desc ? eff - 1 - k : k);
			w.entry_position = POS_W'(cur);
			w.entry_density  = pick_density();
			drive_word(w, 1'b0, '0, quiet);
		end
	endtask

	// result side: check each result against the next expected one, then stall at random
	initial begin
		int      stall_cnt;
		int      steady_cnt;
		int      r;
		result_t want;
		stall_cnt  = 0;
		steady_cnt = 0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result density=%h status=%0d",
						out_bus.density, out_bus.status));
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (out_bus.density !== want.density)
						report_mismatch($sformatf("density %h, expected %h",
							out_bus.density, want.density));
					if (out_bus.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_bus.status, want.status));
				end
			end
			if (steady_cnt > 0) begin
				steady_cnt--;
				out_bus.ready <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_bus.ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3)
					steady_cnt = $urandom_range(50, 300);
				else if (r < 8)
					stall_cnt = $urandom_range(10, 40);
				else if (r < 30)
					stall_cnt = $urandom_range(1, 3);
				out_bus.ready <= (stall_cnt == 0);
			end
		end
	end

	initial begin
		int unsigned      phase_len [NUM_PHASES];
		int unsigned      eff, k;
		logic [PDATA_W-1:0] wdata, rdata;
		longint           lo_b, hi_b;
		bit               need_fill, quiet;
		in_word_t         w;
		phase_len = '{0, 3, 1024, 2047, 17, 1, 1025, 2, 0, 0, 5, 0};
		phase_len[8]  = $urandom_range(4, 64);
		phase_len[9]  = $urandom_range(2, 300);
		phase_len[11] = $urandom_range(2, 1024);

		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		in_bus.valid          <= 1'b0;
		in_bus.command        <= CMD_WRITE;
		in_bus.entry_index    <= '0;
		in_bus.entry_position <= '0;
		in_bus.entry_density  <= '0;
		in_bus.query_position <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read(LEN_ADDR, rdata);
		if (rdata !== PDATA_W'(LEN_RESET))
			report_mismatch($sformatf("table_length after reset %0d, expected %0d",
				rdata, LEN_RESET));

		for (int i = 0; i < PLAN_LEN; i++)
			drive_word(PLAN[i].w, PLAN[i].typed, PLAN[i].res, 1'b0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			wdata              = $urandom;
			wdata[LEN_W-1:0]   = LEN_W'(phase_len[ph]);
			reg_write(LEN_ADDR, wdata);
			len_reg = wdata[LEN_W-1:0];
			reg_read(LEN_ADDR, rdata);
			if (rdata !== PDATA_W'(len_reg))
				report_mismatch($sformatf("table_length read %0d, expected %0d", rdata, len_reg));
			eff   = effective_length(len_reg);
			quiet = ($urandom_range(0, 3) == 0);

			// never let a query touch a slot that was not written
			need_fill = 1'b0;
			for (int unsigned s = 0; s < eff; s++)
				if (!table_written[s])
					need_fill = 1'b1;
			if (need_fill || (eff <= 64 && $urandom_range(0, 1) == 1))
				fill_table(eff, quiet);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				w = noise_word();
				if ($urandom_range(0, 99) < 70) begin
					w.query_position = pick_query(eff);
				end else begin
					w.command       = CMD_WRITE;
					w.entry_density = pick_density();
					if ($urandom_range(0, 99) < 75) begin
						// keep the table sorted: stay between the neighbors, or anywhere when they are out of order
						k    = $urandom_range(0, eff - 1);
						lo_b = (k == 0) ? longint'(POS_MIN) : longint'(pos_tab[k-1]);
						hi_b = (k == eff - 1) ? longint'(POS_MAX) : longint'(pos_tab[k+1]);
						if (lo_b > hi_b) begin
							lo_b = longint'(POS_MIN);
							hi_b = longint'(POS_MAX);
						end
						w.entry_index    = IDX_W'(k);
						w.entry_position = POS_W'(rand_span(lo_b, hi_b));
					end
				end
				drive_word(w, 1'b0, '0, quiet);
			end
		end

		settle();
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));
		$display("Sent %0d words (%0d queries, %0d table writes) over %0d length settings.",
			words_sent, queries_sent, words_sent - queries_sent, NUM_PHASES + 1);
		$display("Checked %0d results against the predictor, %0d mismatches.",
			results_checked, errors);
		if (errors == 0)
			$display("table_linear_interpolator_top test passed");
		else
			$display("table_linear_interpolator_top test failed");
		$finish;
	end

endmodule

@@ table_linear_interpolator_top.f @@
sv/tli_pkg.sv
sv/tli_in_if.sv
sv/tli_out_if.sv
sv/tli_ram.sv
sv/table_linear_interpolator_top.sv
tb/table_linear_interpolator_top_tb.sv
